// ----- hdl/pressure_temperature_compensation_defines.svh -----
// Assertion macros shared by the pressure and temperature compensation block.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ptc_pkg.sv -----
// Shared types, constants and helper functions of the compensation pipeline.
package ptc_pkg;

  localparam logic [1:0] REG_TEMP_COEFFS = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
  localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
  localparam logic [1:0] REG_PRESS_NINE  = 2'd3;

  localparam logic [32:0] TFINE_OFFSET = 33'd128000;
  localparam logic [20:0] PRESS_BASE   = 21'd1048576;
  localparam logic [11:0] NUM_SCALE    = 12'd3125;
  localparam logic [63:0] BASE_ONE     = 64'h0000_8000_0000_0000;
  localparam logic [31:0] TEMP_ROUND   = 32'd128;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } ptc_coeff_t;

  typedef struct packed {
    logic [31:0] temp;
    logic        zero;
    logic        qneg;
  } ptc_side_t;

  function automatic logic [31:0] sar32(logic [31:0] x, int s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] sar64(logic [63:0] x, int s);
    return 64'($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] sx16to32(logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sx16to64(logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sx49to64(logic [48:0] x);
    return {{15{x[48]}}, x};
  endfunction

endpackage

// ----- hdl/ptc_sample_if.sv -----
// Input channel carrying one raw temperature and one raw pressure reading.
interface ptc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

// ----- hdl/ptc_result_if.sv -----
// Output channel carrying compensated temperature, pressure and error flag.
interface ptc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature;
  logic [31:0]        pressure;
  logic               pressure_error;

  modport source (output valid, output temperature, output pressure,
                  output pressure_error, input ready);
  modport sink (input valid, input temperature, input pressure,
                input pressure_error, output ready);
endinterface

// ----- hdl/ptc_front.sv -----
// Temperature formula and pressure numerator and divisor, thirteen stages.
module ptc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [19:0]            raw_t,
  input  logic [19:0]            raw_p,
  input  ptc_pkg::ptc_coeff_t    coeff,
  output logic                   out_valid,
  output logic [63:0]            out_mn,
  output logic [63:0]            out_md,
  output ptc_pkg::ptc_side_t     out_side
);
  import ptc_pkg::*;

  logic [12:0] vld;

  logic [31:0] s1_x, s1_d;
  logic [19:0] s1_p;
  logic [31:0] s2_pa, s2_dd;
  logic [19:0] s2_p;
  logic [31:0] s3_a, s3_pb;
  logic [19:0] s3_p;
  logic [31:0] s4_tf;
  logic [19:0] s4_p;
  logic [31:0] s5_tf, s5_temp;
  logic [19:0] s5_p;
  logic [32:0] s6_v1;
  logic [31:0] s6_mag, s6_temp;
  logic [19:0] s6_p;
  logic [63:0] s7_sq;
  logic signed [48:0] s7_v5, s7_v2;
  logic [31:0] s7_temp;
  logic [19:0] s7_p;
  logic signed [48:0] s8_a6l, s8_a3l, s8_v5, s8_v2;
  logic [31:0] s8_a6h, s8_a3h, s8_temp;
  logic [19:0] s8_p;
  logic [63:0] s9_v2, s9_m3;
  logic signed [48:0] s9_vp2;
  logic [31:0] s9_temp;
  logic [19:0] s9_p;
  logic [63:0] s10_base, s10_numd;
  logic [31:0] s10_temp;
  logic [47:0] s11_bl;
  logic [31:0] s11_bh, s11_nh, s11_temp;
  logic [43:0] s11_nl;
  logic [63:0] s12_den, s12_num;
  logic [31:0] s12_temp;

  logic [31:0] temp_mix, temp_calc;
  logic [32:0] v1_calc;
  logic [20:0] pd_calc;
  logic [63:0] prod_calc, mn_calc, md_calc;

  always_comb begin
    temp_mix  = (s4_tf << 2) + s4_tf + TEMP_ROUND;
    temp_calc = sar32(temp_mix, 8);
    v1_calc   = {s5_tf[31], s5_tf} - TFINE_OFFSET;
    pd_calc   = PRESS_BASE - {1'b0, s9_p};
    prod_calc = {16'd0, s11_bl} + {s11_bh, 32'd0};
    mn_calc   = s12_num[63] ? (64'd0 - s12_num) : s12_num;
    md_calc   = s12_den[63] ? (64'd0 - s12_den) : s12_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[11:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x <= {15'd0, raw_t[19:3]} - {15'd0, coeff.t1, 1'b0};
      s1_d <= {16'd0, raw_t[19:4]} - {16'd0, coeff.t1};
      s1_p <= raw_p;

      s2_pa <= s1_x * sx16to32(coeff.t2);
      s2_dd <= s1_d * s1_d;
      s2_p  <= s1_p;

      s3_a  <= sar32(s2_pa, 11);
      s3_pb <= sar32(s2_dd, 12) * sx16to32(coeff.t3);
      s3_p  <= s2_p;

      s4_tf <= s3_a + sar32(s3_pb, 14);
      s4_p  <= s3_p;

      s5_tf   <= s4_tf;
      s5_temp <= temp_calc;
      s5_p    <= s4_p;

      s6_v1   <= v1_calc;
      s6_mag  <= v1_calc[32] ? 32'(33'd0 - v1_calc) : v1_calc[31:0];
      s6_temp <= s5_temp;
      s6_p    <= s5_p;

      s7_sq   <= {32'd0, s6_mag} * {32'd0, s6_mag};
      s7_v5   <= $signed(s6_v1) * coeff.p5;
      s7_v2   <= $signed(s6_v1) * coeff.p2;
      s7_temp <= s6_temp;
      s7_p    <= s6_p;

      s8_a6l  <= $signed({1'b0, s7_sq[31:0]}) * coeff.p6;
      s8_a6h  <= s7_sq[63:32] * sx16to32(coeff.p6);
      s8_a3l  <= $signed({1'b0, s7_sq[31:0]}) * coeff.p3;
      s8_a3h  <= s7_sq[63:32] * sx16to32(coeff.p3);
      s8_v5   <= s7_v5;
      s8_v2   <= s7_v2;
      s8_temp <= s7_temp;
      s8_p    <= s7_p;

      s9_v2   <= sx49to64(s8_a6l) + {s8_a6h, 32'd0} + (sx49to64(s8_v5) << 17)
                 + (sx16to64(coeff.p4) << 35);
      s9_m3   <= sx49to64(s8_a3l) + {s8_a3h, 32'd0};
      s9_vp2  <= s8_v2;
      s9_temp <= s8_temp;
      s9_p    <= s8_p;

      s10_base <= sar64(s9_m3, 8) + (sx49to64(s9_vp2) << 12) + BASE_ONE;
      s10_numd <= ({43'd0, pd_calc} << 31) - s9_v2;
      s10_temp <= s9_temp;

      s11_bl   <= 48'(s10_base[31:0]) * 48'(coeff.p1);
      s11_bh   <= s10_base[63:32] * {16'd0, coeff.p1};
      s11_nl   <= 44'(s10_numd[31:0]) * 44'(NUM_SCALE);
      s11_nh   <= s10_numd[63:32] * {20'd0, NUM_SCALE};
      s11_temp <= s10_temp;

      s12_den  <= sar64(prod_calc, 33);
      s12_num  <= {20'd0, s11_nl} + {s11_nh, 32'd0};
      s12_temp <= s11_temp;

      out_mn        <= mn_calc;
      out_md        <= (s12_den == 64'd0) ? 64'd1 : md_calc;
      out_side.temp <= s12_temp;
      out_side.zero <= (s12_den == 64'd0);
      out_side.qneg <= s12_num[63] ^ s12_den[63];
    end
  end

  assign out_valid = vld[12];

endmodule

// ----- hdl/ptc_div.sv -----
// Pipelined restoring divider of 64-bit magnitudes, one quotient bit per stage.
module ptc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [63:0]        in_mn,
  input  logic [63:0]        in_md,
  input  ptc_pkg::ptc_side_t in_side,
  output logic               out_valid,
  output logic [63:0]        out_quo,
  output ptc_pkg::ptc_side_t out_side
);
  import ptc_pkg::*;

  logic [63:0] vld;
  logic [63:0] rem [64];
  logic [63:0] dvd [64];
  logic [63:0] dsr [64];
  ptc_side_t   sd  [64];

  logic [63:0] r_src [64];
  logic [63:0] q_src [64];
  logic [63:0] d_src [64];
  ptc_side_t   s_src [64];
  logic [64:0] trial [64];
  logic [63:0] rem_next [64];
  logic [63:0] dvd_next [64];

  always_comb begin
    r_src[0] = '0;
    q_src[0] = in_mn;
    d_src[0] = in_md;
    s_src[0] = in_side;
    for (int k = 1; k < 64; k++) begin
      r_src[k] = rem[k-1];
      q_src[k] = dvd[k-1];
      d_src[k] = dsr[k-1];
      s_src[k] = sd[k-1];
    end
    for (int k = 0; k < 64; k++) begin
      trial[k]    = {r_src[k], q_src[k][63]} - {1'b0, d_src[k]};
      rem_next[k] = trial[k][64] ? {r_src[k][62:0], q_src[k][63]} : trial[k][63:0];
      dvd_next[k] = {q_src[k][62:0], ~trial[k][64]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[62:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 64; k++) begin
        rem[k] <= rem_next[k];
        dvd[k] <= dvd_next[k];
        dsr[k] <= d_src[k];
        sd[k]  <= s_src[k];
      end
    end
  end

  assign out_valid = vld[63];
  assign out_quo   = dvd[63];
  assign out_side  = sd[63];

endmodule

// ----- hdl/ptc_back.sv -----
// Quotient sign fix, quadratic pressure correction and final scaling, six stages.
module ptc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [63:0]        in_quo,
  input  ptc_pkg::ptc_side_t in_side,
  input  ptc_pkg::ptc_coeff_t coeff,
  output logic               out_valid,
  output logic [31:0]        out_temp,
  output logic [31:0]        out_press,
  output logic               out_err
);
  import ptc_pkg::*;

  logic [5:0] vld;

  logic [63:0] sa_q;
  ptc_side_t   sa_side;
  logic [63:0] sb_q, sb_sqll;
  logic [31:0] sb_sqlh, sb_c2h;
  logic signed [48:0] sb_c2l;
  ptc_side_t   sb_side;
  logic [63:0] sc_q, sc_phsq, sc_c2;
  ptc_side_t   sc_side;
  logic [63:0] sd_q, sd_c2;
  logic signed [48:0] sd_el;
  logic [31:0] sd_eh;
  ptc_side_t   sd_side;
  logic [63:0] se_q, se_c2, se_c1;
  ptc_side_t   se_side;

  logic [63:0] ph_calc, final_calc;

  always_comb begin
    ph_calc    = sar64(sa_q, 13);
    final_calc = sar64(se_q + se_c1 + se_c2, 8) + (sx16to64(coeff.p7) << 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_q    <= in_side.qneg ? (64'd0 - in_quo) : in_quo;
      sa_side <= in_side;

      sb_sqll <= {32'd0, ph_calc[31:0]} * {32'd0, ph_calc[31:0]};
      sb_sqlh <= ph_calc[31:0] * ph_calc[63:32];
      sb_c2l  <= $signed({1'b0, sa_q[31:0]}) * coeff.p8;
      sb_c2h  <= sa_q[63:32] * sx16to32(coeff.p8);
      sb_q    <= sa_q;
      sb_side <= sa_side;

      sc_phsq <= sb_sqll + {sb_sqlh[30:0], 33'd0};
      sc_c2   <= sar64(sx49to64(sb_c2l) + {sb_c2h, 32'd0}, 19);
      sc_q    <= sb_q;
      sc_side <= sb_side;

      sd_el   <= $signed({1'b0, sc_phsq[31:0]}) * coeff.p9;
      sd_eh   <= sc_phsq[63:32] * sx16to32(coeff.p9);
      sd_q    <= sc_q;
      sd_c2   <= sc_c2;
      sd_side <= sc_side;

      se_c1   <= sar64(sx49to64(sd_el) + {sd_eh, 32'd0}, 25);
      se_q    <= sd_q;
      se_c2   <= sd_c2;
      se_side <= sd_side;

      out_temp  <= se_side.temp;
      out_press <= se_side.zero ? 32'd0 : {8'd0, final_calc[31:8]};
      out_err   <= se_side.zero;
    end
  end

  assign out_valid = vld[5];

endmodule

// ----- hdl/pressure_temperature_compensation.sv -----
// Top level: calibration registers, compensation pipeline and output handshake.
// Pipeline: 83 register stages from an accepted sample to its result beat:
// 13 for the polynomial front end, 64 for the divider, 6 for the correction.
// Throughput: one sample per cycle; the whole pipeline holds while a result stalls.
// Reset clears all valid bits and the calibration registers to zero.
`include "pressure_temperature_compensation_defines.svh"

module pressure_temperature_compensation (
  input  logic         clk,
  input  logic         rst,
  ptc_sample_if.sink   sample,
  ptc_result_if.source result,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import ptc_pkg::*;

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;

  ptc_coeff_t coeff;
  logic       adv;
  logic       front_valid, div_valid, back_valid;
  logic [63:0] front_mn, front_md, div_quo;
  ptc_side_t  front_side, div_side;
  logic [31:0] back_temp, back_press;
  logic       back_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_COEFFS: temp_coeffs       <= cfg_data[47:0];
        REG_PRESS_LOW:   press_coeffs_low  <= cfg_data;
        REG_PRESS_HIGH:  press_coeffs_high <= cfg_data;
        REG_PRESS_NINE:  press_coeff_nine  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    coeff.t1 = temp_coeffs[15:0];
    coeff.t2 = temp_coeffs[31:16];
    coeff.t3 = temp_coeffs[47:32];
    coeff.p1 = press_coeffs_low[15:0];
    coeff.p2 = press_coeffs_low[31:16];
    coeff.p3 = press_coeffs_low[47:32];
    coeff.p4 = press_coeffs_low[63:48];
    coeff.p5 = press_coeffs_high[15:0];
    coeff.p6 = press_coeffs_high[31:16];
    coeff.p7 = press_coeffs_high[47:32];
    coeff.p8 = press_coeffs_high[63:48];
    coeff.p9 = press_coeff_nine;
  end

  assign adv          = ~back_valid | result.ready;
  assign sample.ready = adv;

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample.valid),
    .raw_t     (sample.raw_temperature),
    .raw_p     (sample.raw_pressure),
    .coeff     (coeff),
    .out_valid (front_valid),
    .out_mn    (front_mn),
    .out_md    (front_md),
    .out_side  (front_side)
  );

  ptc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .in_mn     (front_mn),
    .in_md     (front_md),
    .in_side   (front_side),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_quo    (div_quo),
    .in_side   (div_side),
    .coeff     (coeff),
    .out_valid (back_valid),
    .out_temp  (back_temp),
    .out_press (back_press),
    .out_err   (back_err)
  );

  assign result.valid          = back_valid;
  assign result.temperature    = back_temp;
  assign result.pressure       = back_press;
  assign result.pressure_error = back_err;

  `PTC_ASSERT_NOW(a_err_zero_press, result.valid && result.pressure_error, result.pressure == 32'd0, "pressure not zero on divisor error")
  `PTC_ASSERT_NOW(a_press_range, result.valid, result.pressure[31:24] == 8'd0, "pressure exceeds 24 bits")
  `PTC_ASSERT_NOW(a_reset_quiet, $past(rst), !result.valid, "result beat right after reset")

endmodule

// ----- tb/pressure_temperature_compensation_tb.sv -----
// Testbench for the pressure and temperature compensation block with a scoreboard class.
module pressure_temperature_compensation_tb;
  import ptc_pkg::*;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic        pressure_error;
  } comp_result_t;

  class comp_scoreboard;
    logic [47:0] tc;
    logic [63:0] pl;
    logic [63:0] ph;
    logic [15:0] p9r;
    comp_result_t pending[$];
    int errors;
    int checked;
    int zero_div;

    function new();
      tc = '0;
      pl = '0;
      ph = '0;
      p9r = '0;
      errors = 0;
      checked = 0;
      zero_div = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_TEMP_COEFFS: tc = val[47:0];
        REG_PRESS_LOW: pl = val;
        REG_PRESS_HIGH: ph = val;
        REG_PRESS_NINE: p9r = val[15:0];
        default: ;
      endcase
    endfunction

    function comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
      comp_result_t r;
      logic [31:0] t1, t2, t3, a, d, b, t_fine, dd;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] v1, v2, p, phi, c1, c2;
      t1 = {16'd0, tc[15:0]};
      t2 = {{16{tc[31]}}, tc[31:16]};
      t3 = {{16{tc[47]}}, tc[47:32]};
      p1 = {48'd0, pl[15:0]};
      p2 = {{48{pl[31]}}, pl[31:16]};
      p3 = {{48{pl[47]}}, pl[47:32]};
      p4 = {{48{pl[63]}}, pl[63:48]};
      p5 = {{48{ph[15]}}, ph[15:0]};
      p6 = {{48{ph[31]}}, ph[31:16]};
      p7 = {{48{ph[47]}}, ph[47:32]};
      p8 = {{48{ph[63]}}, ph[63:48]};
      p9 = {{48{p9r[15]}}, p9r};
      a = 32'(({12'd0, adc_t} >> 3) - (t1 << 1));
      a = 32'($signed(32'(a * t2)) >>> 11);
      d = 32'(({12'd0, adc_t} >> 4) - t1);
      dd = 32'($signed(32'(d * d)) >>> 12);
      b = 32'($signed(32'(dd * t3)) >>> 14);
      t_fine = a + b;
      r.temperature = 32'($signed(32'(t_fine * 32'd5 + 32'd128)) >>> 8);
      v1 = 64'($signed(t_fine)) - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      r.pressure = '0;
      r.pressure_error = 1'b0;
      if (v1 == 0) begin
        r.pressure_error = 1'b1;
      end else begin
        p = 64'sd1048576 - 64'($signed({1'b0, adc_p}));
        p = ((p <<< 31) - v2) * 64'sd3125;
        if (p == 64'sh8000_0000_0000_0000 && v1 == -64'sd1) p = p;
        else p = p / v1;
        phi = p >>> 13;
        c1 = (p9 * phi * phi) >>> 25;
        c2 = (p8 * p) >>> 19;
        p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
        r.pressure = {8'd0, p[31:8]};
      end
      return r;
    endfunction

    function void note_sample(logic [19:0] adc_t, logic [19:0] adc_p);
      comp_result_t r;
      r = compensate(adc_t, adc_p);
      if (r.pressure_error) zero_div++;
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] t, logic [31:0] p, logic e);
      comp_result_t x;
      if (pending.size() == 0) begin
        $error("result beat with no expectation: t=%h p=%h e=%b", t, p, e);
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      if (t !== x.temperature) begin
        $error("temperature expected %h actual %h", x.temperature, t);
        errors++;
      end
      if (p !== x.pressure) begin
        $error("pressure expected %h actual %h", x.pressure, p);
        errors++;
      end
      if (e !== x.pressure_error) begin
        $error("pressure_error expected %b actual %b", x.pressure_error, e);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int send_idle = 0;
  int recv_stall = 0;

  ptc_sample_if sample ();
  ptc_result_if result ();

  comp_scoreboard sb = new();

  pressure_temperature_compensation dut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    sample.valid = 1'b0;
    sample.raw_temperature = '0;
    sample.raw_pressure = '0;
    result.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample.valid && sample.ready)
        sb.note_sample(sample.raw_temperature, sample.raw_pressure);
      if (result.valid && result.ready)
        sb.check_result(result.temperature, result.pressure, result.pressure_error);
      result.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [19:0] t, logic [19:0] p);
    while ($urandom_range(99) < send_idle) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.raw_temperature <= t;
    sample.raw_pressure <= p;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
  endtask

  task automatic drain();
    sample.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_typical();
    write_reg(REG_TEMP_COEFFS, 64'({16'hFC18, 16'd26435, 16'd27504}));
    write_reg(REG_PRESS_LOW, {16'd2855, 16'hD0D0, 16'hFF4E, 16'd36477});
    write_reg(REG_PRESS_HIGH, {16'd15500, 16'hFFF9, 16'hFF8C, 16'd140});
    write_reg(REG_PRESS_NINE, 64'd6000);
  endtask

  task automatic load_random();
    write_reg(REG_TEMP_COEFFS, {$urandom, $urandom});
    write_reg(REG_PRESS_LOW, {$urandom, $urandom});
    write_reg(REG_PRESS_HIGH, {$urandom, $urandom});
    write_reg(REG_PRESS_NINE, {$urandom, $urandom});
  endtask

  task automatic load_near_typical();
    write_reg(REG_TEMP_COEFFS, 64'({16'($urandom_range(65535)),
                                    16'(25000 + $urandom_range(3000)),
                                    16'(26000 + $urandom_range(4000))}));
    write_reg(REG_PRESS_LOW, {16'($urandom), 16'($urandom), 16'($urandom),
                              16'(30000 + $urandom_range(10000))});
    write_reg(REG_PRESS_HIGH, {$urandom, $urandom});
    write_reg(REG_PRESS_NINE, 64'($urandom));
  endtask

  initial begin
    int ph;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Reset coefficients give P1 = 0, hence a zero divisor.
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
    load_typical();
    send_sample(20'd519888, 20'd415148);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    drain();
    write_reg(REG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_NINE, 64'hFFFF_FFFF_FFFF_8000);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
    write_reg(REG_TEMP_COEFFS, 64'h0000_8000_8000_0000);
    write_reg(REG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
    write_reg(REG_PRESS_HIGH, 64'h7FFF_7FFF_8000_7FFF);
    write_reg(REG_PRESS_NINE, 64'h7FFF);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    drain();
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 74; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 74; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      if (ph == 0) load_typical();
      else if (ph % 3 == 0) load_random();
      else load_near_typical();
      repeat (125) begin
        if ($urandom_range(3) == 0) send_sample(20'($urandom), 20'($urandom));
        else send_sample(20'(400000 + $urandom_range(200000)),
                         20'(250000 + $urandom_range(300000)));
      end
      drain();
    end
    $display("Checked %0d result beats over corner coefficients, 8 coefficient sets and 4 idle patterns.",
             sb.checked);
    $display("%0d of them hit the zero divisor case.", sb.zero_div);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("pressure_temperature_compensation verification clean");
    else
      $display("pressure_temperature_compensation verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("pressure_temperature_compensation verification failed");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/ptc_pkg.sv
hdl/ptc_sample_if.sv
hdl/ptc_result_if.sv
hdl/ptc_front.sv
hdl/ptc_div.sv
hdl/ptc_back.sv
hdl/pressure_temperature_compensation.sv
tb/pressure_temperature_compensation_tb.sv
